>>> hdl/yuvbgra_pkg.sv
// shared types, constants and coefficient table for the yuv to bgra converter
package yuvbgra_pkg;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 11;
    localparam int SCALE_W  = 9;
    localparam int CHROMA_W = 8;
    localparam int PROD_W   = COEF_W + CHROMA_W;
    localparam int LUMA_W   = SAMPLE_W + SCALE_W;
    localparam int SUM_W    = 20;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_SELECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_SWING    = 2'd1;

    // luma handling
    localparam logic [SAMPLE_W-1:0] LUMA_BLACK    = 8'd16;
    localparam logic [SCALE_W-1:0]  SCALE_LIMITED = 9'd298;
    localparam logic [SCALE_W-1:0]  SCALE_FULL    = 9'd256;
    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE  = 8'd255;
    localparam logic [SAMPLE_W-1:0] CHAN_MAX      = 8'd255;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = 20'sd128;

    typedef enum logic [1:0] {
        MATRIX_BT601   = 2'd0,
        MATRIX_BT709   = 2'd1,
        MATRIX_BT2020  = 2'd2,
        MATRIX_UNKNOWN = 2'd3
    } matrix_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] chroma_blue;
        logic [SAMPLE_W-1:0] chroma_red;
    } pix_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] alpha;
    } pix_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] r_v;
        logic signed [COEF_W-1:0] g_u;
        logic signed [COEF_W-1:0] g_v;
        logic signed [COEF_W-1:0] b_u;
    } coef_set_t;

    // operands after the first stage
    typedef struct packed {
        logic [SAMPLE_W-1:0]        luma_op;
        logic [SCALE_W-1:0]         luma_scale;
        logic signed [CHROMA_W-1:0] u;
        logic signed [CHROMA_W-1:0] v;
        coef_set_t                  coef;
    } prep_t;

    // channel sums before rounding
    typedef struct packed {
        logic signed [SUM_W-1:0] blue;
        logic signed [SUM_W-1:0] green;
        logic signed [SUM_W-1:0] red;
    } sum_t;

    // chroma coefficients per matrix and range
    function automatic coef_set_t coef_lookup(input matrix_t matrix, input logic full);
        coef_set_t c;
        unique case (matrix)
            MATRIX_BT709:
            begin
                if (full)
                    c = '{r_v: 11'sd403, g_u: -11'sd48, g_v: -11'sd120, b_u: 11'sd475};
                else
                    c = '{r_v: 11'sd459, g_u: -11'sd55, g_v: -11'sd136, b_u: 11'sd541};
            end
            MATRIX_BT2020:
            begin
                if (full)
                    c = '{r_v: 11'sd378, g_u: -11'sd42, g_v: -11'sd146, b_u: 11'sd482};
                else
                    c = '{r_v: 11'sd430, g_u: -11'sd48, g_v: -11'sd167, b_u: 11'sd548};
            end
            MATRIX_BT601, MATRIX_UNKNOWN:
            begin
                if (full)
                    c = '{r_v: 11'sd359, g_u: -11'sd88, g_v: -11'sd183, b_u: 11'sd454};
                else
                    c = '{r_v: 11'sd409, g_u: -11'sd100, g_v: -11'sd208, b_u: 11'sd516};
            end
            default:
            begin
                c = '{r_v: 11'sd409, g_u: -11'sd100, g_v: -11'sd208, b_u: 11'sd516};
            end
        endcase
        return c;
    endfunction

endpackage

>>> hdl/yuvbgra_prep.sv
// first stage: luma offset, chroma centering and coefficient selection
module yuvbgra_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  yuvbgra_pkg::pix_in_t  pix,
    input  yuvbgra_pkg::matrix_t  matrix_select,
    input  logic                  full_swing,
    output logic                  prep_valid,
    output yuvbgra_pkg::prep_t    prep
);
    import yuvbgra_pkg::*;

    logic  valid_reg;
    prep_t prep_reg;
    prep_t prep_next;

    // luma operand and scale, chroma recentered around zero
    always_comb
    begin
        prep_next.coef = coef_lookup(matrix_select, full_swing);
        prep_next.u    = signed'({~pix.chroma_blue[SAMPLE_W-1], pix.chroma_blue[SAMPLE_W-2:0]});
        prep_next.v    = signed'({~pix.chroma_red[SAMPLE_W-1], pix.chroma_red[SAMPLE_W-2:0]});
        if (full_swing)
        begin
            prep_next.luma_op    = pix.luma;
            prep_next.luma_scale = SCALE_FULL;
        end
        else
        begin
            prep_next.luma_op    = (pix.luma > LUMA_BLACK) ? (pix.luma - LUMA_BLACK) : '0;
            prep_next.luma_scale = SCALE_LIMITED;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // operand register
    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    assign prep_valid = valid_reg;
    assign prep       = prep_reg;

endmodule

>>> hdl/yuvbgra_mac.sv
// second and third stages: products, then channel sums
module yuvbgra_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                prep_valid,
    input  yuvbgra_pkg::prep_t  prep,
    output logic                sum_valid,
    output yuvbgra_pkg::sum_t   sums
);
    import yuvbgra_pkg::*;

    logic                     mul_valid_reg;
    logic                     sum_valid_reg;
    logic [LUMA_W-1:0]        yy_reg;
    logic signed [PROD_W-1:0] bu_reg;
    logic signed [PROD_W-1:0] gu_reg;
    logic signed [PROD_W-1:0] gv_reg;
    logic signed [PROD_W-1:0] rv_reg;
    logic [LUMA_W-1:0]        yy_next;
    logic signed [PROD_W-1:0] bu_next;
    logic signed [PROD_W-1:0] gu_next;
    logic signed [PROD_W-1:0] gv_next;
    logic signed [PROD_W-1:0] rv_next;
    logic signed [SUM_W-1:0]  yy_ext;
    sum_t                     sum_reg;
    sum_t                     sum_next;

    // products
    always_comb
    begin
        yy_next = LUMA_W'(prep.luma_op) * LUMA_W'(prep.luma_scale);
        bu_next = PROD_W'(prep.coef.b_u) * PROD_W'(prep.u);
        gu_next = PROD_W'(prep.coef.g_u) * PROD_W'(prep.u);
        gv_next = PROD_W'(prep.coef.g_v) * PROD_W'(prep.v);
        rv_next = PROD_W'(prep.coef.r_v) * PROD_W'(prep.v);
    end

    // channel sums
    always_comb
    begin
        yy_ext         = signed'({{(SUM_W-LUMA_W){1'b0}}, yy_reg});
        sum_next.blue  = yy_ext + SUM_W'(bu_reg);
        sum_next.green = yy_ext + SUM_W'(gu_reg) + SUM_W'(gv_reg);
        sum_next.red   = yy_ext + SUM_W'(rv_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= prep_valid;
            sum_valid_reg <= mul_valid_reg;
        end
    end

    // product and sum registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yy_reg  <= yy_next;
            bu_reg  <= bu_next;
            gu_reg  <= gu_next;
            gv_reg  <= gv_next;
            rv_reg  <= rv_next;
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sums      = sum_reg;

endmodule

>>> hdl/yuvbgra_sat.sv
// last stage: rounding, floor shift by 8 and saturation to 0..255
module yuvbgra_sat (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  sum_valid,
    input  yuvbgra_pkg::sum_t     sums,
    output logic                  out_valid,
    output yuvbgra_pkg::pix_out_t pix
);
    import yuvbgra_pkg::*;

    logic     valid_reg;
    pix_out_t pix_reg;
    pix_out_t pix_next;

    // add half, keep bits 15:8, clamp negative to 0 and overflow to 255
    function automatic logic [SAMPLE_W-1:0] sat_channel(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] t;
        logic [SAMPLE_W-1:0]     q;
        t = sum + ROUND_HALF;
        if (t[SUM_W-1])
            q = '0;
        else if (|t[SUM_W-2:2*SAMPLE_W])
            q = CHAN_MAX;
        else
            q = t[2*SAMPLE_W-1:SAMPLE_W];
        return q;
    endfunction

    always_comb
    begin
        pix_next.blue  = sat_channel(sums.blue);
        pix_next.green = sat_channel(sums.green);
        pix_next.red   = sat_channel(sums.red);
        pix_next.alpha = ALPHA_OPAQUE;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= sum_valid;
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (en)
            pix_reg <= pix_next;
    end

    assign out_valid = valid_reg;
    assign pix       = pix_reg;

endmodule

>>> hdl/yuv_to_bgra_pixel_convert_unit.sv
// top level of the yuv to bgra pixel converter
//
// Converts one 8-bit Y/Cb/Cr pixel to 8-bit blue, green, red and opaque alpha
// via channel sums in signed 12.8 fixed point. The pixel channel (pixel_valid,
// pixel_stall, pixel) takes one word per clock unless stalled; the bgra
// channel (bgra_valid, bgra_stall, bgra) gives one word per accepted pixel,
// in order. A word moves at a clock edge where valid is high and stall is low.
// From the accepting edge a word moves through operand prep, multiply, sum,
// and round and saturate, one register stage each, the first loaded at that
// edge; bgra_valid rises when the last is loaded. Throughput is one pixel per
// clock unless stalled, set by the single shared stage enable of the pipeline.
// When bgra_stall is high with a word waiting at the output, the whole
// pipeline holds and pixel_stall goes high in the same cycle; any empty
// stage still takes a new word when the output is free.
// The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// matrix_select at index 0 and full_swing at index 1; other indexes are
// ignored. cfg_ready is always high. Write only while the pipeline is empty.
// Reset clears all stage valid bits and selects BT.601 limited range.
module yuv_to_bgra_pixel_convert_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pixel_valid,
    output logic                                 pixel_stall,
    input  yuvbgra_pkg::pix_in_t                 pixel,
    output logic                                 bgra_valid,
    input  logic                                 bgra_stall,
    output yuvbgra_pkg::pix_out_t                bgra,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [yuvbgra_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [yuvbgra_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import yuvbgra_pkg::*;

    matrix_t  matrix_select_reg;
    logic     full_swing_reg;
    logic     en;
    logic     prep_valid;
    prep_t    prep;
    logic     sum_valid;
    sum_t     sums;

    // pipeline advances unless a word waits at a stalled output
    assign en          = !(bgra_valid && bgra_stall);
    assign pixel_stall = !en;
    assign cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_select_reg <= MATRIX_BT601;
            full_swing_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MATRIX_SELECT)
                matrix_select_reg <= matrix_t'(cfg_data[1:0]);
            else if (cfg_index == CFG_FULL_SWING)
                full_swing_reg <= cfg_data[0];
        end
    end

    yuvbgra_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (pixel_valid),
        .pix           (pixel),
        .matrix_select (matrix_select_reg),
        .full_swing    (full_swing_reg),
        .prep_valid    (prep_valid),
        .prep          (prep)
    );

    yuvbgra_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prep_valid (prep_valid),
        .prep       (prep),
        .sum_valid  (sum_valid),
        .sums       (sums)
    );

    yuvbgra_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .sum_valid (sum_valid),
        .sums      (sums),
        .out_valid (bgra_valid),
        .pix       (bgra)
    );

endmodule
